[rtl/core/ffua_pkg.sv]
// Package of the first-fit unit allocator: request and result types,
// command and status codes. It depends on nothing else.
`timescale 1ns / 1ps

package ffua_pkg;

    localparam int ID_W    = 8;
    localparam int SIZE_W  = 11;
    localparam int STATUS_W = 2;
    localparam int START_W = 10;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   owner_id;
        logic [SIZE_W-1:0] block_size;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start_unit;
    } t_res;

endpackage

[rtl/core/ffua_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps

module ffua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ffua_engine.sv]
// Sequencer of the allocator: clearing pass, map scan and marking over the
// ownership map. It depends on ffua_pkg and ffua_ram.
`timescale 1ns / 1ps

module ffua_engine
    import ffua_pkg::*;
#(
    parameter int MEM_UNITS = 1024,
    parameter int ID_BITS   = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ack
);

    localparam int AW = $clog2(MEM_UNITS);
    localparam int CW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;
    localparam logic [CW-1:0] UNITS = CW'(MEM_UNITS);
    localparam logic [CW-1:0] LAST  = CW'(MEM_UNITS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic               r_cmd, n_cmd;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [CW-1:0]      r_size, n_size;
    logic [CW-1:0]      r_issue, n_issue;
    logic               r_vld, n_vld;
    logic [CW-1:0]      r_chk, n_chk;
    logic [CW-1:0]      r_run_len, n_run_len;
    logic [CW-1:0]      r_run_start, n_run_start;
    logic [CW-1:0]      r_mark, n_mark;
    logic [CW-1:0]      r_mcnt, n_mcnt;
    t_res               r_res, n_res;

    logic [15:0]        id_wide;
    logic [ID_BITS-1:0] id_eff;
    logic [CW-1:0]      size_ext;
    logic [CW-1:0]      start_c;
    logic [CW-1:0]      room;
    logic               found;
    logic               ram_we;
    logic [ID_BITS-1:0] ram_wdata;
    logic [ID_BITS-1:0] ram_rdata;

    assign id_wide  = {8'd0, i_req.owner_id};
    assign id_eff   = id_wide[ID_BITS-1:0];
    assign size_ext = CW'(i_req.block_size);
    assign start_c  = (r_run_len == '0) ? r_chk : r_run_start;
    assign room     = UNITS - r_chk;

    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_MARK) && (r_mcnt != '0));
    assign ram_wdata = ((r_state == S_MARK) && (r_cmd == CMD_ALLOC)) ? r_id : '0;

    ffua_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(MEM_UNITS)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_mark[AW-1:0]),
        .i_wdata(ram_wdata),
        .i_raddr(r_issue[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_size      = r_size;
        n_issue     = r_issue;
        n_vld       = 1'b0;
        n_chk       = r_chk;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_mark      = r_mark;
        n_mcnt      = r_mcnt;
        n_res       = r_res;
        found       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_mark = r_mark + 1'b1;
                if (r_mark == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd     = i_req.command;
                    n_id      = id_eff;
                    n_size    = size_ext;
                    n_issue   = '0;
                    n_run_len = '0;
                    n_state   = S_SCAN;
                    if (i_req.command == CMD_ALLOC) begin
                        if ((id_eff == '0) || (size_ext == '0) || (size_ext > UNITS)) begin
                            n_res   = '{status: ST_NOSPACE, start_unit: '0};
                            n_state = S_DONE;
                        end
                    end else if (id_eff == '0) begin
                        n_res   = '{status: ST_NOTFOUND, start_unit: '0};
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_issue < UNITS) begin
                    n_vld   = 1'b1;
                    n_chk   = r_issue;
                    n_issue = r_issue + 1'b1;
                end
                if (r_vld) begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (ram_rdata != '0) begin
                            n_run_len = '0;
                        end else begin
                            n_run_start = start_c;
                            n_run_len   = r_run_len + 1'b1;
                            if ((r_run_len + 1'b1) == r_size) begin
                                found   = 1'b1;
                                n_mark  = start_c;
                                n_mcnt  = r_size;
                                n_res   = '{status: ST_DONE, start_unit: start_c[START_W-1:0]};
                                n_state = S_MARK;
                            end
                        end
                    end else if (ram_rdata == r_id) begin
                        found   = 1'b1;
                        n_mark  = r_chk;
                        n_mcnt  = (r_size < room) ? r_size : room;
                        n_res   = '{status: ST_DONE, start_unit: r_chk[START_W-1:0]};
                        n_state = S_MARK;
                    end
                    if (!found && (r_chk == LAST)) begin
                        n_res.status     = (r_cmd == CMD_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
                        n_res.start_unit = '0;
                        n_state          = S_DONE;
                    end
                end
            end
            S_MARK: begin
                if (r_mcnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_mark = r_mark + 1'b1;
                    n_mcnt = r_mcnt - 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mark  <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mark  <= n_mark;
            r_vld   <= n_vld;
        end
        r_cmd       <= n_cmd;
        r_id        <= n_id;
        r_size      <= n_size;
        r_issue     <= n_issue;
        r_chk       <= n_chk;
        r_run_len   <= n_run_len;
        r_run_start <= n_run_start;
        r_mcnt      <= n_mcnt;
        r_res       <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

[rtl/core/first_fit_unit_allocator.sv]
// First-fit unit allocator top level: stream ports, engine and output register.
// It depends on ffua_pkg and ffua_engine.
//
// After reset the block sweeps the ownership map to free, one unit a cycle, and
// accepts no request until that pass is over. Each request then takes one
// transfer in and gives one transfer out. A request is scanned through the
// single read port of the map, one unit per cycle; an allocate or free that finds
// its units then marks or clears them one by one before its result is given.
// Requests rejected on their fields skip the scan and go straight to the result.
// The block accepts a new request while a finished result still waits in the
// output register.
`timescale 1ns / 1ps

module first_fit_unit_allocator
    import ffua_pkg::*;
#(
    parameter int MEM_UNITS = 1024,
    parameter int ID_BITS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // owner_id [7:0], block_size [18:8], zero [23:19]
    input  logic        s_axis_tuser,   // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // start_unit [9:0], zero [15:10]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);

    t_req req;
    t_res res;
    logic res_valid;
    logic res_ack;
    logic r_m_valid;
    t_res r_m_res;

    assign req = '{command: s_axis_tuser,
                   owner_id: s_axis_tdata[7:0],
                   block_size: s_axis_tdata[18:8]};

    ffua_engine #(
        .MEM_UNITS(MEM_UNITS),
        .ID_BITS  (ID_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req      (req),
        .o_req_ready(s_axis_tready),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ack  (res_ack)
    );

    assign res_ack = res_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ack) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_ack) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_res.start_unit};
    assign m_axis_tuser  = r_m_res.status;

endmodule

[rtl/core/ffua_checker.sv]
// Port-level checker of the first-fit unit allocator and its bind to the top level.
// It depends on ffua_pkg and first_fit_unit_allocator.
`timescale 1ns / 1ps

module ffua_checker
    import ffua_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_DONE || m_axis_tuser == ST_NOSPACE
                           || m_axis_tuser == ST_NOTFOUND))
        else $error("undefined status code");

    a_error_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DONE |-> m_axis_tdata == 16'd0)
        else $error("failed request reports a nonzero start unit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind first_fit_unit_allocator ffua_checker u_ffua_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
